// ----- rtl/kpvt_pkg.sv -----
// Shared types, constants and a saturation helper for the position-velocity tracker.
package kpvt_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = DATA_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SUM_W     = DATA_W + 4;

  localparam logic signed [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VARP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VARV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_POS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_VEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR  = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] measurement;
    logic                     restart;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pred_position;
    logic signed [DATA_W-1:0] pred_velocity;
    logic signed [DATA_W-1:0] innovation;
    logic signed [DATA_W-1:0] gain_position;
    logic signed [DATA_W-1:0] gain_velocity;
    logic signed [DATA_W-1:0] est_position;
    logic signed [DATA_W-1:0] est_velocity;
    logic signed [DATA_W-1:0] var_position;
    logic signed [DATA_W-1:0] var_velocity;
    logic signed [DATA_W-1:0] cov_pos_vel;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic                     done;
    logic                     clip;
    logic signed [DATA_W-1:0] quot;
  } div_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREDICT, ST_INNOV, ST_DIV0_GO, ST_DIV0_WAIT, ST_DIV1_GO,
    ST_DIV1_WAIT, ST_MUL_LOAD, ST_MUL_USE, ST_LATCH, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_XE, OP_VE, OP_N00, OP_N01, OP_N10, OP_N11
  } mul_op_t;

  function automatic sat_t clip_sum(input logic signed [SUM_W-1:0] v);
    sat_t r;
    if (v > SUM_W'(VMAX)) begin
      r.clip = 1'b1;
      r.val  = VMAX;
    end else if (v < SUM_W'(VMIN)) begin
      r.clip = 1'b1;
      r.val  = VMIN;
    end else begin
      r.clip = 1'b0;
      r.val  = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/kpvt_if.sv -----
// Valid-ready channel interfaces for measurements and results.
interface kpvt_in_if import kpvt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface kpvt_out_if import kpvt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/kpvt_div.sv -----
// Restoring serial divider giving a saturated signed fixed-point quotient, one bit a cycle.
module kpvt_div import kpvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W+1:0] den,
  output div_out_t                 res
);

  logic                   busy;
  logic                   done;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   neg;
  logic                   zero;
  logic [DIV_STEPS-1:0]   dvd;
  logic [DIV_STEPS-1:0]   quo;
  logic [DATA_W:0]        ud;
  logic [DATA_W:0]        rem;
  logic [DATA_W:0]        rem_next;
  logic [DATA_W+1:0]      rem_sh;
  logic                   qbit;
  logic [DATA_W-1:0]      un_in;
  logic [DATA_W:0]        ud_in;

  assign un_in  = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
  assign ud_in  = den[DATA_W+1] ? (DATA_W+1)'(-den) : den[DATA_W:0];
  assign rem_sh = {rem, dvd[DIV_STEPS-1]};
  assign qbit   = rem_sh >= {1'b0, ud};
  assign rem_next = qbit ? (DATA_W+1)'(rem_sh - {1'b0, ud}) : rem_sh[DATA_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[DATA_W-1] ^ den[DATA_W+1];
      zero <= den == '0;
      dvd  <= {un_in, {FRAC_W{1'b0}}};
      ud   <= ud_in;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DIV_STEPS-2:0], 1'b0};
      quo <= {quo[DIV_STEPS-2:0], qbit};
    end
  end

  always_comb begin
    res.done = done;
    res.clip = 1'b0;
    if (zero) begin
      res.quot = '0;
    end else if (|quo[DIV_STEPS-1:DATA_W-1]) begin
      res.clip = 1'b1;
      res.quot = neg ? VMIN : VMAX;
    end else begin
      res.quot = neg ? DATA_W'(-quo[DATA_W-1:0]) : quo[DATA_W-1:0];
    end
  end

endmodule

// ----- rtl/kpvt_mul.sv -----
// Shared fixed-point multiplier with registered product, rounding and saturation.
module kpvt_mul import kpvt_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output sat_t                     res
);

  logic                    neg;
  logic [2*DATA_W-1:0]     prod;
  logic [DATA_W-1:0]       ua;
  logic [DATA_W-1:0]       ub;
  logic [2*DATA_W-1:0]     rnd;
  logic [2*DATA_W-FRAC_W-1:0] m;

  assign ua  = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign ub  = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign rnd = prod + (2*DATA_W)'(1 << (FRAC_W - 1));
  assign m   = rnd[2*DATA_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (load) begin
      neg  <= a[DATA_W-1] ^ b[DATA_W-1];
      prod <= ua * ub;
    end
  end

  always_comb begin
    res.clip = 1'b0;
    if (neg) begin
      if (m > (2*DATA_W-FRAC_W)'({1'b1, {(DATA_W-1){1'b0}}})) begin
        res.clip = 1'b1;
        res.val  = VMIN;
      end else begin
        res.val = DATA_W'(-m[DATA_W-1:0]);
      end
    end else begin
      if (m > (2*DATA_W-FRAC_W)'(VMAX)) begin
        res.clip = 1'b1;
        res.val  = VMAX;
      end else begin
        res.val = m[DATA_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/kalman_position_velocity_tracker.sv -----
// Top level of the two-state constant-velocity Kalman tracker with its sequencer.
// One measurement passes through prediction and innovation, two passes of the serial
// divider for the gains, six load-and-use passes of the shared multiplier and a latch
// of the result before the result is valid.
// The next measurement is taken at the earliest in the cycle after the result has been
// transferred, so no new measurement is taken while one is still in work.
// Synchronous reset loads the default registers and the default initial state.
module kalman_position_velocity_tracker import kpvt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  kpvt_in_if.sink              meas,
  kpvt_out_if.source           result
);

  state_t  state, state_next;
  mul_op_t op;

  logic signed [DATA_W-1:0] init_pos, init_vel, noise_x;
  logic [DATA_W-2:0]        init_varp, init_varv, noise_pos, noise_vel, meas_var;

  logic signed [DATA_W-1:0] position, velocity, cov_00, cov_01, cov_10, cov_11;
  logic signed [DATA_W-1:0] z, xp, vp, pa, pb, pc, pd, y, k0, k1;
  logic signed [DATA_W-1:0] xe, ve, n00, n01, n10, n11;
  logic signed [DATA_W+1:0] s;
  logic                     flag;
  logic                     out_valid;
  out_item_t                out_data;

  logic                     div_start, mul_load, accept;
  logic signed [DATA_W-1:0] div_num, mul_a, mul_b, base;
  logic                     do_sub;
  div_out_t                 div_res;
  sat_t                     mul_res;
  sat_t                     sat_xp, sat_a, sat_b, sat_c, sat_d, sat_y, sat_acc;

  assign accept = meas.valid && meas.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (meas.valid) state_next = ST_PREDICT;
      ST_PREDICT:   state_next = ST_INNOV;
      ST_INNOV:     state_next = ST_DIV0_GO;
      ST_DIV0_GO:   state_next = ST_DIV0_WAIT;
      ST_DIV0_WAIT: if (div_res.done) state_next = ST_DIV1_GO;
      ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
      ST_DIV1_WAIT: if (div_res.done) state_next = ST_MUL_LOAD;
      ST_MUL_LOAD:  state_next = ST_MUL_USE;
      ST_MUL_USE:   state_next = (op == OP_N11) ? ST_LATCH : ST_MUL_LOAD;
      ST_LATCH:     state_next = ST_OUT;
      ST_OUT:       if (result.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    meas.ready = state == ST_IDLE;
    div_start  = (state == ST_DIV0_GO) || (state == ST_DIV1_GO);
    div_num    = (state == ST_DIV1_GO) ? pc : pa;
    mul_load   = state == ST_MUL_LOAD;
  end

  always_comb begin
    case (op)
      OP_XE:   begin mul_a = k0; mul_b = y;  base = xp; do_sub = 1'b0; end
      OP_VE:   begin mul_a = k1; mul_b = y;  base = vp; do_sub = 1'b0; end
      OP_N00:  begin mul_a = k0; mul_b = pa; base = pa; do_sub = 1'b1; end
      OP_N01:  begin mul_a = k0; mul_b = pb; base = pb; do_sub = 1'b1; end
      OP_N10:  begin mul_a = k1; mul_b = pa; base = pc; do_sub = 1'b1; end
      OP_N11:  begin mul_a = k1; mul_b = pb; base = pd; do_sub = 1'b1; end
      default: begin mul_a = k0; mul_b = y;  base = xp; do_sub = 1'b0; end
    endcase
  end

  assign sat_xp = clip_sum(SUM_W'(position) + SUM_W'(velocity));
  assign sat_a  = clip_sum(SUM_W'(cov_00) + SUM_W'(cov_01) + SUM_W'(cov_10)
                           + SUM_W'(cov_11) + SUM_W'({1'b0, noise_pos}));
  assign sat_b  = clip_sum(SUM_W'(cov_01) + SUM_W'(cov_11) + SUM_W'(noise_x));
  assign sat_c  = clip_sum(SUM_W'(cov_10) + SUM_W'(cov_11) + SUM_W'(noise_x));
  assign sat_d  = clip_sum(SUM_W'(cov_11) + SUM_W'({1'b0, noise_vel}));
  assign sat_y  = clip_sum(SUM_W'(z) - SUM_W'(xp));
  assign sat_acc = do_sub ? clip_sum(SUM_W'(base) - SUM_W'(mul_res.val))
                          : clip_sum(SUM_W'(base) + SUM_W'(mul_res.val));

  kpvt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s),
    .res   (div_res)
  );

  kpvt_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .a    (mul_a),
    .b    (mul_b),
    .res  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      init_pos  <= '0;
      init_vel  <= DATA_W'(327680);
      init_varp <= (DATA_W-1)'(6553600);
      init_varv <= (DATA_W-1)'(1638400);
      noise_pos <= (DATA_W-1)'(6554);
      noise_x   <= DATA_W'(6554);
      noise_vel <= (DATA_W-1)'(13107);
      meas_var  <= (DATA_W-1)'(262144);
      position  <= '0;
      velocity  <= DATA_W'(327680);
      cov_00    <= DATA_W'(6553600);
      cov_01    <= '0;
      cov_10    <= '0;
      cov_11    <= DATA_W'(1638400);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_POS:  init_pos  <= cfg_data;
          REG_INIT_VEL:  init_vel  <= cfg_data;
          REG_INIT_VARP: init_varp <= cfg_data[DATA_W-2:0];
          REG_INIT_VARV: init_varv <= cfg_data[DATA_W-2:0];
          REG_NOISE_POS: noise_pos <= cfg_data[DATA_W-2:0];
          REG_NOISE_X:   noise_x   <= cfg_data;
          REG_NOISE_VEL: noise_vel <= cfg_data[DATA_W-2:0];
          REG_MEAS_VAR:  meas_var  <= cfg_data[DATA_W-2:0];
          default:       ;
        endcase
      end
      if (accept && meas.data.restart) begin
        position <= init_pos;
        velocity <= init_vel;
        cov_00   <= DATA_W'({1'b0, init_varp});
        cov_01   <= '0;
        cov_10   <= '0;
        cov_11   <= DATA_W'({1'b0, init_varv});
      end
      if (state == ST_LATCH) begin
        out_valid <= 1'b1;
        position  <= xe;
        velocity  <= ve;
        cov_00    <= n00;
        cov_01    <= n01;
        cov_10    <= n10;
        cov_11    <= n11;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        z    <= meas.data.measurement;
        flag <= 1'b0;
        op   <= OP_XE;
      end
      ST_PREDICT: begin
        xp   <= sat_xp.val;
        vp   <= velocity;
        pa   <= sat_a.val;
        pb   <= sat_b.val;
        pc   <= sat_c.val;
        pd   <= sat_d.val;
        flag <= flag | sat_xp.clip | sat_a.clip | sat_b.clip | sat_c.clip | sat_d.clip;
      end
      ST_INNOV: begin
        y    <= sat_y.val;
        s    <= (DATA_W+2)'(pa) + (DATA_W+2)'({1'b0, meas_var});
        flag <= flag | sat_y.clip;
      end
      ST_DIV0_WAIT: begin
        if (div_res.done) begin
          k0   <= div_res.quot;
          flag <= flag | div_res.clip;
        end
      end
      ST_DIV1_WAIT: begin
        if (div_res.done) begin
          k1   <= div_res.quot;
          flag <= flag | div_res.clip;
        end
      end
      ST_MUL_USE: begin
        flag <= flag | mul_res.clip | sat_acc.clip;
        op   <= mul_op_t'(op + 3'd1);
        case (op)
          OP_XE:   xe  <= sat_acc.val;
          OP_VE:   ve  <= sat_acc.val;
          OP_N00:  n00 <= sat_acc.val;
          OP_N01:  n01 <= sat_acc.val;
          OP_N10:  n10 <= sat_acc.val;
          OP_N11:  n11 <= sat_acc.val;
          default: ;
        endcase
      end
      ST_LATCH: begin
        out_data.pred_position <= xp;
        out_data.pred_velocity <= vp;
        out_data.innovation    <= y;
        out_data.gain_position <= k0;
        out_data.gain_velocity <= k1;
        out_data.est_position  <= xe;
        out_data.est_velocity  <= ve;
        out_data.var_position  <= n00;
        out_data.var_velocity  <= n11;
        out_data.cov_pos_vel   <= n01;
        out_data.saturated     <= flag;
      end
      default: ;
    endcase
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_ready_vs_result: assert property (@(posedge clk) disable iff (rst)
    !(meas.ready && result.valid))
    else $error("measurement taken while a result is pending");

  a_accept_predicts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_PREDICT)
    else $error("transfer did not start prediction");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIV0_WAIT || state == ST_DIV1_WAIT))
    else $error("divider finished outside a wait state");

  a_latch_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_LATCH |=> result.valid && state == ST_OUT)
    else $error("latched result not presented");

endmodule
